[design/qau_pkg.sv]
// Package for the quaternion arithmetic unit: widths, op codes and the
// pipeline stage records. Used by quaternion_arithmetic_unit; no dependencies.
package qau_pkg;

    // Fixed-point format of every component.
    localparam int FRAC_BITS  = 14;
    localparam int COMP_WIDTH = 16;

    localparam int CW  = COMP_WIDTH;
    // Product of two components.
    localparam int PW  = 2 * CW;
    // Signed sum of four doubled products plus the constant 1.0.
    localparam int SW  = (PW + 4 > 2 * FRAC_BITS + 3) ? PW + 4 : 2 * FRAC_BITS + 3;
    // Square root of a sum of four squares.
    localparam int RW  = CW + 1;
    // Square root remainder.
    localparam int RMW = 2 * RW + 1;
    // Normalize quotient, never above 1.0.
    localparam int QW  = FRAC_BITS + 1;
    // Division remainder.
    localparam int DW  = RW + QW;
    // Stages from rounding through the last quotient bit.
    localparam int NMID = RW + QW + 2;

    // Component lanes.
    localparam int IX = 0;
    localparam int IY = 1;
    localparam int IZ = 2;
    localparam int IW = 3;

    typedef enum logic [2:0] {
        OP_MUL_QUAT = 3'd0,
        OP_MUL_VEC  = 3'd1,
        OP_CONJ     = 3'd2,
        OP_DOT      = 3'd3,
        OP_MAG      = 3'd4,
        OP_NORM     = 3'd5,
        OP_AXES     = 3'd6,
        OP_NONE     = 3'd7
    } t_op;

    // One product term of a lane.
    typedef struct packed {
        logic [CW-1:0] a;
        logic [CW-1:0] b;
        logic          neg;
    } t_term;

    // Record carried through the root and divide stages.
    typedef struct packed {
        t_op                   op;
        logic                  last;
        logic [3:0]            asgn;
        logic [3:0][CW-1:0]    amag;
        logic [CW-1:0]         rx;
        logic [CW-1:0]         ry;
        logic [CW-1:0]         rz;
        logic [CW-1:0]         rw;
        logic [CW-1:0]         rs;
        logic                  ovf;
        logic [RW-1:0]         root;
        logic [RMW-1:0]        srem;
        logic [3:0][DW-1:0]    drem;
        logic [3:0][QW-1:0]    quo;
    } t_mid;

    // One result beat.
    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic [CW-1:0] w;
        logic [CW-1:0] s;
        logic          ovf;
        logic          zm;
        logic          last;
    } t_res;

endpackage

[design/quaternion_arithmetic_unit.sv]
// Quaternion arithmetic unit, Q2.14: products, conjugate, dot, magnitude,
// normalize and rotation axes in one stall-controlled pipeline. Uses qau_pkg.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+--------------------------------------------
//  input   | i_valid | o_ready | i_op, i_a_x..i_a_w, i_b_x..i_b_w
//  output  | o_valid | i_ready | o_out_x..o_out_w, o_scalar, o_overflow,
//          |         |         | o_zero_magnitude, o_last
//
// One beat per cycle enters unless the output stalls; rotation axes hold the
// input until all three axis vectors are issued. Beats pass the product, sum
// and round stages, then the one-bit-per-stage root and quotient chains.
// Synchronous active-low reset clears the valid bits only. A stall at the
// output freezes every stage at once; nothing is dropped or repeated.
module quaternion_arithmetic_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [2:0]                i_op,
    input  logic [qau_pkg::CW-1:0]    i_a_x,
    input  logic [qau_pkg::CW-1:0]    i_a_y,
    input  logic [qau_pkg::CW-1:0]    i_a_z,
    input  logic [qau_pkg::CW-1:0]    i_a_w,
    input  logic [qau_pkg::CW-1:0]    i_b_x,
    input  logic [qau_pkg::CW-1:0]    i_b_y,
    input  logic [qau_pkg::CW-1:0]    i_b_z,
    input  logic [qau_pkg::CW-1:0]    i_b_w,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [qau_pkg::CW-1:0]    o_out_x,
    output logic [qau_pkg::CW-1:0]    o_out_y,
    output logic [qau_pkg::CW-1:0]    o_out_z,
    output logic [qau_pkg::CW-1:0]    o_out_w,
    output logic [qau_pkg::CW-1:0]    o_scalar,
    output logic                      o_overflow,
    output logic                      o_zero_magnitude,
    output logic                      o_last
);
    import qau_pkg::*;

    // Saturate a wide signed value; returns {overflow, value}.
    function automatic logic [CW:0] sat_sw(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return {1'b1, hi[CW-1:0]};
        end else if (v < lo) begin
            return {1'b1, lo[CW-1:0]};
        end
        return {1'b0, v[CW-1:0]};
    endfunction

    // Round half up from 2*FRAC_BITS to FRAC_BITS fraction bits, saturate.
    function automatic logic [CW:0] rnd(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t = v + (SW'(1) <<< (FRAC_BITS - 1));
        t = t >>> FRAC_BITS;
        return sat_sw(t);
    endfunction

    function automatic t_term term(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                   input logic neg);
        t_term t;
        t.a   = a;
        t.b   = b;
        t.neg = neg;
        return t;
    endfunction

    // One root bit: try setting bit b of the root.
    function automatic t_mid sqrt_step(input t_mid m, input int b);
        t_mid           r;
        logic [RMW-1:0] trial;
        r     = m;
        trial = (RMW'(m.root) << (b + 1)) + (RMW'(1) << (2 * b));
        if (m.srem >= trial) begin
            r.srem = m.srem - trial;
            r.root = m.root | (RW'(1) << b);
        end
        return r;
    endfunction

    // Load the dividends: |c| * 1.0 + mag / 2.
    function automatic t_mid div_prep(input t_mid m);
        t_mid r;
        r = m;
        for (int l = 0; l < 4; l++) begin
            r.drem[l] = (DW'(m.amag[l]) << FRAC_BITS) + DW'(m.root >> 1);
            r.quo[l]  = '0;
        end
        return r;
    endfunction

    // One quotient bit in all four lanes.
    function automatic t_mid div_step(input t_mid m, input int b);
        t_mid          r;
        logic [DW-1:0] d;
        r = m;
        d = DW'(m.root) << b;
        for (int l = 0; l < 4; l++) begin
            if (m.drem[l] >= d) begin
                r.drem[l] = m.drem[l] - d;
                r.quo[l]  = m.quo[l] | (QW'(1) << b);
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stall control
    // ---------------------------------------------------------------
    logic w_en;
    logic w_in_done;

    logic                r_out_v;
    t_res                r_out;

    logic                r_in_v;
    t_op                 r_op;
    logic [1:0]          r_sub;
    logic [3:0][CW-1:0]  r_a;
    logic [3:0][CW-1:0]  r_b;

    // Advance every stage when the output register is free or being taken.
    assign w_en      = !r_out_v || i_ready;
    assign w_in_done = !r_in_v || (r_op != OP_AXES) || (r_sub == 2'd2);
    assign o_ready   = w_en && w_in_done;

    // Input stage: hold rotation-axes beats for three passes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_en) begin
            if (w_in_done) begin
                r_in_v <= i_valid;
                r_op   <= t_op'(i_op);
                r_sub  <= 2'd0;
                r_a    <= {i_a_w, i_a_z, i_a_y, i_a_x};
                r_b    <= {i_b_w, i_b_z, i_b_y, i_b_x};
            end else begin
                r_sub  <= r_sub + 2'd1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: pick operands per lane and multiply
    // ---------------------------------------------------------------
    t_term               w_tm [4][4];
    logic                w_dbl;
    logic [3:0]          w_cst;
    logic                w_last;
    logic [CW-1:0]       w_bw;

    logic                r_p1_v;
    t_op                 r_p1_op;
    logic                r_p1_last;
    logic [3:0][CW-1:0]  r_p1_a;
    logic signed [PW-1:0] r_prod [4][4];
    logic [3:0]          r_neg [4];
    logic                r_dbl;
    logic [3:0]          r_cst;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            for (int t = 0; t < 4; t++) begin
                w_tm[l][t] = '0;
            end
        end
        w_dbl  = 1'b0;
        w_cst  = '0;
        w_last = 1'b1;
        w_bw   = (r_op == OP_MUL_VEC) ? '0 : r_b[IW];
        case (r_op)
            OP_MUL_QUAT, OP_MUL_VEC: begin
                w_tm[IX][0] = term(r_a[IX], w_bw,     1'b0);
                w_tm[IX][1] = term(r_a[IW], r_b[IX], 1'b0);
                w_tm[IX][2] = term(r_a[IY], r_b[IZ], 1'b0);
                w_tm[IX][3] = term(r_a[IZ], r_b[IY], 1'b1);
                w_tm[IY][0] = term(r_a[IY], w_bw,     1'b0);
                w_tm[IY][1] = term(r_a[IW], r_b[IY], 1'b0);
                w_tm[IY][2] = term(r_a[IZ], r_b[IX], 1'b0);
                w_tm[IY][3] = term(r_a[IX], r_b[IZ], 1'b1);
                w_tm[IZ][0] = term(r_a[IZ], w_bw,     1'b0);
                w_tm[IZ][1] = term(r_a[IW], r_b[IZ], 1'b0);
                w_tm[IZ][2] = term(r_a[IX], r_b[IY], 1'b0);
                w_tm[IZ][3] = term(r_a[IY], r_b[IX], 1'b1);
                w_tm[IW][0] = term(r_a[IW], w_bw,     1'b0);
                w_tm[IW][1] = term(r_a[IX], r_b[IX], 1'b1);
                w_tm[IW][2] = term(r_a[IY], r_b[IY], 1'b1);
                w_tm[IW][3] = term(r_a[IZ], r_b[IZ], 1'b1);
            end
            OP_DOT: begin
                for (int t = 0; t < 4; t++) begin
                    w_tm[IW][t] = term(r_a[t], r_b[t], 1'b0);
                end
            end
            OP_MAG, OP_NORM: begin
                for (int t = 0; t < 4; t++) begin
                    w_tm[IW][t] = term(r_a[t], r_a[t], 1'b0);
                end
            end
            OP_AXES: begin
                w_dbl  = 1'b1;
                w_last = (r_sub == 2'd2);
                case (r_sub)
                    2'd0: begin
                        // forward
                        w_tm[IX][0] = term(r_a[IX], r_a[IZ], 1'b0);
                        w_tm[IX][1] = term(r_a[IW], r_a[IY], 1'b1);
                        w_tm[IY][0] = term(r_a[IY], r_a[IZ], 1'b0);
                        w_tm[IY][1] = term(r_a[IW], r_a[IX], 1'b0);
                        w_tm[IZ][0] = term(r_a[IX], r_a[IX], 1'b1);
                        w_tm[IZ][1] = term(r_a[IY], r_a[IY], 1'b1);
                        w_cst[IZ]   = 1'b1;
                    end
                    2'd1: begin
                        // up
                        w_tm[IX][0] = term(r_a[IX], r_a[IY], 1'b0);
                        w_tm[IX][1] = term(r_a[IW], r_a[IZ], 1'b0);
                        w_tm[IY][0] = term(r_a[IX], r_a[IX], 1'b1);
                        w_tm[IY][1] = term(r_a[IZ], r_a[IZ], 1'b1);
                        w_cst[IY]   = 1'b1;
                        w_tm[IZ][0] = term(r_a[IY], r_a[IZ], 1'b0);
                        w_tm[IZ][1] = term(r_a[IW], r_a[IX], 1'b1);
                    end
                    default: begin
                        // right
                        w_tm[IX][0] = term(r_a[IY], r_a[IY], 1'b1);
                        w_tm[IX][1] = term(r_a[IZ], r_a[IZ], 1'b1);
                        w_cst[IX]   = 1'b1;
                        w_tm[IY][0] = term(r_a[IX], r_a[IY], 1'b0);
                        w_tm[IY][1] = term(r_a[IW], r_a[IZ], 1'b1);
                        w_tm[IZ][0] = term(r_a[IX], r_a[IZ], 1'b0);
                        w_tm[IZ][1] = term(r_a[IW], r_a[IY], 1'b0);
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v    <= r_in_v;
            r_p1_op   <= r_op;
            r_p1_last <= w_last;
            r_p1_a    <= r_a;
            r_dbl     <= w_dbl;
            r_cst     <= w_cst;
            for (int l = 0; l < 4; l++) begin
                for (int t = 0; t < 4; t++) begin
                    r_prod[l][t] <= $signed(w_tm[l][t].a) * $signed(w_tm[l][t].b);
                    r_neg[l][t]  <= w_tm[l][t].neg;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: signed lane sums
    // ---------------------------------------------------------------
    logic signed [SW-1:0] w_sum [4];

    logic                 r_s2_v;
    t_op                  r_s2_op;
    logic                 r_s2_last;
    logic [3:0][CW-1:0]   r_s2_a;
    logic signed [SW-1:0] r_sum [4];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_sum[l] = '0;
            for (int t = 0; t < 4; t++) begin
                if (r_neg[l][t]) begin
                    w_sum[l] = w_sum[l] - SW'(r_prod[l][t]);
                end else begin
                    w_sum[l] = w_sum[l] + SW'(r_prod[l][t]);
                end
            end
            if (r_dbl) begin
                w_sum[l] = w_sum[l] <<< 1;
            end
            if (r_cst[l]) begin
                w_sum[l] = w_sum[l] + (SW'(1) <<< (2 * FRAC_BITS));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v    <= r_p1_v;
            r_s2_op   <= r_p1_op;
            r_s2_last <= r_p1_last;
            r_s2_a    <= r_p1_a;
            for (int l = 0; l < 4; l++) begin
                r_sum[l] <= w_sum[l];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: round and saturate, seed the root chain
    // ---------------------------------------------------------------
    t_mid              n_m [NMID];
    t_mid              r_m [NMID];
    logic [NMID-1:0]   r_mv;

    logic [CW:0]       w_rl [4];
    logic [CW:0]       w_cj [3];

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_rl[l] = rnd(r_sum[l]);
        end
        for (int l = 0; l < 3; l++) begin
            w_cj[l] = sat_sw(-SW'($signed(r_s2_a[l])));
        end
        n_m[0]      = '0;
        n_m[0].op   = r_s2_op;
        n_m[0].last = r_s2_last;
        for (int l = 0; l < 4; l++) begin
            n_m[0].asgn[l] = r_s2_a[l][CW-1];
            n_m[0].amag[l] = r_s2_a[l][CW-1] ? -r_s2_a[l] : r_s2_a[l];
        end
        n_m[0].srem = r_sum[IW][RMW-1:0];
        case (r_s2_op)
            OP_MUL_QUAT, OP_MUL_VEC: begin
                n_m[0].rx  = w_rl[IX][CW-1:0];
                n_m[0].ry  = w_rl[IY][CW-1:0];
                n_m[0].rz  = w_rl[IZ][CW-1:0];
                n_m[0].rw  = w_rl[IW][CW-1:0];
                n_m[0].ovf = w_rl[IX][CW] | w_rl[IY][CW] | w_rl[IZ][CW] | w_rl[IW][CW];
            end
            OP_CONJ: begin
                n_m[0].rx  = w_cj[IX][CW-1:0];
                n_m[0].ry  = w_cj[IY][CW-1:0];
                n_m[0].rz  = w_cj[IZ][CW-1:0];
                n_m[0].rw  = r_s2_a[IW];
                n_m[0].ovf = w_cj[IX][CW] | w_cj[IY][CW] | w_cj[IZ][CW];
            end
            OP_DOT: begin
                n_m[0].rs  = w_rl[IW][CW-1:0];
                n_m[0].ovf = w_rl[IW][CW];
            end
            OP_AXES: begin
                n_m[0].rx  = w_rl[IX][CW-1:0];
                n_m[0].ry  = w_rl[IY][CW-1:0];
                n_m[0].rz  = w_rl[IZ][CW-1:0];
                n_m[0].ovf = w_rl[IX][CW] | w_rl[IY][CW] | w_rl[IZ][CW];
            end
            default: begin
            end
        endcase
    end

    // Root bits, then dividend load, then quotient bits, one per stage.
    for (genvar k = 1; k < NMID; k++) begin : g_mid
        if (k <= RW) begin : g_root
            assign n_m[k] = sqrt_step(r_m[k-1], RW - k);
        end else if (k == RW + 1) begin : g_prep
            assign n_m[k] = div_prep(r_m[k-1]);
        end else begin : g_div
            assign n_m[k] = div_step(r_m[k-1], QW - (k - RW - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= '0;
        end else if (w_en) begin
            r_mv <= {r_mv[NMID-2:0], r_s2_v};
            for (int k = 0; k < NMID; k++) begin
                r_m[k] <= n_m[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output stage: finish magnitude and normalize, register the beat
    // ---------------------------------------------------------------
    t_mid          w_f;
    t_res          n_out;
    logic [CW:0]   w_ms;
    logic [CW:0]   w_nq [4];

    assign w_f = r_m[NMID-1];

    always_comb begin
        w_ms = sat_sw($signed(SW'(w_f.root)));
        for (int l = 0; l < 4; l++) begin
            if (w_f.asgn[l]) begin
                w_nq[l] = sat_sw(-$signed(SW'(w_f.quo[l])));
            end else begin
                w_nq[l] = sat_sw($signed(SW'(w_f.quo[l])));
            end
        end
        n_out      = '0;
        n_out.last = w_f.last;
        case (w_f.op)
            OP_MAG: begin
                n_out.s   = w_ms[CW-1:0];
                n_out.ovf = w_ms[CW];
            end
            OP_NORM: begin
                if (w_f.root == '0) begin
                    n_out.zm = 1'b1;
                end else begin
                    n_out.x   = w_nq[IX][CW-1:0];
                    n_out.y   = w_nq[IY][CW-1:0];
                    n_out.z   = w_nq[IZ][CW-1:0];
                    n_out.w   = w_nq[IW][CW-1:0];
                    n_out.ovf = w_nq[IX][CW] | w_nq[IY][CW] | w_nq[IZ][CW] | w_nq[IW][CW];
                end
            end
            default: begin
                n_out.x   = w_f.rx;
                n_out.y   = w_f.ry;
                n_out.z   = w_f.rz;
                n_out.w   = w_f.rw;
                n_out.s   = w_f.rs;
                n_out.ovf = w_f.ovf;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_mv[NMID-1];
            r_out   <= n_out;
        end
    end

    assign o_valid          = r_out_v;
    assign o_out_x          = r_out.x;
    assign o_out_y          = r_out.y;
    assign o_out_z          = r_out.z;
    assign o_out_w          = r_out.w;
    assign o_scalar         = r_out.s;
    assign o_overflow       = r_out.ovf;
    assign o_zero_magnitude = r_out.zm;
    assign o_last           = r_out.last;

endmodule
